// ===== rtl/lsab_pkg.sv =====
// Package for the light-sensor auto-brightness block.
// Holds widths, words, queue job type, divider handshake types and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package lsab_pkg;

	// Samples in one averaging block
	localparam int WINDOW = 100;

	localparam int SENSE_W = 12;
	localparam int LEVEL_W = 8;
	localparam int SUM_W   = 19;
	localparam int CNT_W   = 7;

	// Block average by reciprocal multiply: floor(sum * AVG_RECIP / 2^AVG_SHIFT).
	// Exact for any sum below 2^SUM_W and WINDOW up to 128, since the rounding
	// error of the reciprocal stays below 2^7.
	localparam int AVG_SHIFT   = 26;
	localparam int AVG_RECIP_W = AVG_SHIFT + 1;
	localparam int AVG_RECIP   = ((1 << AVG_SHIFT) + WINDOW - 1) / WINDOW;
	localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;

	// Serial divider: dividend width, divisor width, step counter width
	localparam int DIV_W     = 30;
	localparam int DVS_W     = 13;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// Job queue between front and back (power-of-two depth)
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SENSE_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SENSE_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX = 3'd3;

	typedef struct packed {
		logic               command;
		logic [SENSE_W-1:0] sample;
		logic [LEVEL_W-1:0] manual_level;
	} item_word_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] brightness;
		logic               from_sensor;
	} result_word_t;

	typedef struct packed {
		logic [SENSE_W-1:0] sense_min;
		logic [SENSE_W-1:0] sense_max;
		logic [LEVEL_W-1:0] level_min;
		logic [LEVEL_W-1:0] level_max;
	} cfg_t;

	// One unit of work for the back end: a full block sum or a manual level
	typedef struct packed {
		logic               is_auto;
		logic [SUM_W-1:0]   sum;
		logic [LEVEL_W-1:0] level;
	} job_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_SIGN,
		B_MAP,
		B_HOLD
	} back_state_t;

endpackage

// ===== rtl/light_sensor_auto_brightness_top.sv =====
// Light-sensor auto brightness: averages sensor samples over blocks of WINDOW
// and maps the average to a brightness level; manual requests pass straight out.
// Item channel: item_valid / item_stall / item. An item is taken when item_valid
// is high and item_stall low. item_stall rises only when the two-entry job queue
// is full, so sensor samples are normally taken every cycle.
// Result channel: result_valid / result_stall / result, held while stalled.
// A manual request with a nonzero level is registered in the job queue, then in the
// output register, which raises result_valid; level zero gives nothing.
// The sample that closes a block raises result_valid after these steps: reciprocal
// multiply for the average, map multiply, divider start, one pass of the serial
// divider (one quotient bit a cycle), clamp and hold; when sense_min equals
// sense_max the divider is skipped. Words leave in the order their items arrived.
// Config: cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is always high.
// Indexes 0..3 are sense_min, sense_max, level_min, level_max; others are dropped.
// Reset (arst_n low) clears the accumulator, queue and output, and loads
// sense range 0..4095 and level range 0..255.
// Depends on lsab_pkg, lsab_front, lsab_queue, lsab_back (with lsab_div).
`timescale 1ns / 1ps

module light_sensor_auto_brightness_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  lsab_pkg::item_word_t              item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output lsab_pkg::result_word_t            result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lsab_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lsab_pkg::SENSE_W-1:0]      cfg_data
);
	import lsab_pkg::*;

	cfg_t cfg_q;
	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t pop_job;

	assign cfg_ready  = 1'b1;
	assign item_stall = q_full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sense_min <= '0;
			cfg_q.sense_max <= '1;
			cfg_q.level_min <= '0;
			cfg_q.level_max <= '1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_SENSE_MIN) begin
				cfg_q.sense_min <= cfg_data;
			end
			if (cfg_index == REG_SENSE_MAX) begin
				cfg_q.sense_max <= cfg_data;
			end
			if (cfg_index == REG_LEVEL_MIN) begin
				cfg_q.level_min <= cfg_data[LEVEL_W-1:0];
			end
			if (cfg_index == REG_LEVEL_MAX) begin
				cfg_q.level_max <= cfg_data[LEVEL_W-1:0];
			end
		end
	end

	lsab_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_word  (item),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	lsab_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	lsab_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_job        (pop_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== rtl/lsab_front.sv =====
// Front end: accepts item words, accumulates sensor samples over a block,
// and pushes manual requests and full block sums as jobs. Depends on lsab_pkg.
`timescale 1ns / 1ps

module lsab_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  lsab_pkg::item_word_t item_word,
	input  logic               q_full,
	output logic               push,
	output lsab_pkg::job_t     push_job
);
	import lsab_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic [SUM_W-1:0] sum_n;
	logic [CNT_W:0]   cnt_n;
	logic             block_full;

	assign accept     = item_valid && !q_full;
	assign sum_n      = sum_q + SUM_W'(item_word.sample);
	assign cnt_n      = {1'b0, cnt_q} + (CNT_W+1)'(1);
	assign block_full = (cnt_n >= (CNT_W+1)'(WINDOW));

	// Job out: nonzero manual level, or a closed block
	always_comb begin
		push     = 1'b0;
		push_job = '0;
		if (accept) begin
			if (item_word.command) begin
				push           = (item_word.manual_level != '0);
				push_job.level = item_word.manual_level;
			end else if (block_full) begin
				push             = 1'b1;
				push_job.is_auto = 1'b1;
				push_job.sum     = sum_n;
			end
		end
	end

	// Accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept && !item_word.command) begin
			if (block_full) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_n;
				cnt_q <= cnt_n[CNT_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/lsab_queue.sv =====
// Small job queue between front and back end, flip-flop storage.
// Depends on lsab_pkg.
`timescale 1ns / 1ps

module lsab_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lsab_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output lsab_pkg::job_t pop_job,
	output logic           empty
);
	import lsab_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   fill_q;

	assign full    = (fill_q == (QPTR_W+1)'(QDEPTH));
	assign empty   = (fill_q == '0);
	assign pop_job = mem_q[rd_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ===== rtl/lsab_div.sv =====
// Serial restoring divider, one quotient bit per cycle, unsigned.
// Used by the range mapping. Depends on lsab_pkg.
`timescale 1ns / 1ps

module lsab_div (
	input  logic               clk,
	input  logic               arst_n,
	input  lsab_pkg::div_req_t req,
	output lsab_pkg::div_rsp_t rsp
);
	import lsab_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     acc_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W:0]       rem_sh;
	logic [DVS_W:0]       rem_sub;
	logic                 qbit;

	// One restoring step
	assign rem_sh  = {rem_q, acc_q[DIV_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign qbit    = (rem_sh >= {1'b0, dvs_q});

	assign rsp.done     = done_q;
	assign rsp.quotient = acc_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
		end
	end

	// Datapath: dividend shifts out the top as quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[DIV_W-2:0], qbit};
			rem_q <= qbit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

endmodule

// ===== rtl/lsab_back.sv =====
// Back end: takes jobs from the queue, averages block sums by reciprocal multiply,
// maps them through the serial divider, clamps, and holds the result word.
// Depends on lsab_pkg, lsab_div.
`timescale 1ns / 1ps

module lsab_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lsab_pkg::cfg_t         cfg,
	input  logic                   q_empty,
	input  lsab_pkg::job_t         q_job,
	output logic                   pop,
	output logic                   result_valid,
	input  logic                   result_stall,
	output lsab_pkg::result_word_t result
);
	import lsab_pkg::*;

	back_state_t         state_q;
	back_state_t         state_d;
	div_req_t            div_req;
	div_rsp_t            div_rsp;
	logic                out_valid_q;
	result_word_t        out_q;
	logic                out_free;
	logic                load_out;
	result_word_t        load_word;
	logic [SUM_W-1:0]    avg_q;
	logic signed [DIV_W-1:0] prod_q;
	logic                neg_q;
	logic [LEVEL_W-1:0]  res_q;

	logic [AVG_PROD_W-1:0]     avg_prod;
	logic signed [SUM_W+1:0]   diff_a;
	logic signed [LEVEL_W:0]   diff_l;
	logic signed [DVS_W-1:0]   diff_s;
	logic signed [DIV_W-1:0]   prod;
	logic [DIV_W-1:0]          prod_mag;
	logic [DVS_W-1:0]          dvs_mag;
	logic signed [DIV_W+1:0]   q_signed;
	logic signed [DIV_W+1:0]   t_raw;
	logic signed [DIV_W+1:0]   lmin_w;
	logic signed [DIV_W+1:0]   lmax_w;
	logic [LEVEL_W-1:0]        t_clamp;

	lsab_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Block average: sum / WINDOW as a multiply by the scaled reciprocal
	assign avg_prod = AVG_PROD_W'(q_job.sum) * AVG_PROD_W'(AVG_RECIP);

	// Mapping arithmetic
	assign diff_a   = $signed({2'b00, avg_q}) - $signed({{(SUM_W-SENSE_W+2){1'b0}}, cfg.sense_min});
	assign diff_l   = $signed({1'b0, cfg.level_max}) - $signed({1'b0, cfg.level_min});
	assign diff_s   = $signed({1'b0, cfg.sense_max}) - $signed({1'b0, cfg.sense_min});
	assign prod     = DIV_W'(diff_a) * DIV_W'(diff_l);
	assign prod_mag = prod_q[DIV_W-1] ? DIV_W'(-prod_q) : DIV_W'(prod_q);
	assign dvs_mag  = diff_s[DVS_W-1] ? DVS_W'(-diff_s) : DVS_W'(diff_s);

	// Signed quotient, offset, then clamp high first and low second
	assign q_signed = neg_q ? -$signed({2'b00, div_rsp.quotient})
	                        : $signed({2'b00, div_rsp.quotient});
	assign lmin_w   = $signed({{(DIV_W-LEVEL_W+2){1'b0}}, cfg.level_min});
	assign lmax_w   = $signed({{(DIV_W-LEVEL_W+2){1'b0}}, cfg.level_max});
	assign t_raw    = q_signed + lmin_w;

	always_comb begin
		if (t_raw > lmax_w || lmin_w > lmax_w) begin
			t_clamp = cfg.level_max;
		end else if (t_raw < lmin_w) begin
			t_clamp = cfg.level_min;
		end else begin
			t_clamp = t_raw[LEVEL_W-1:0];
		end
	end

	// Next state and controls
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		load_out  = 1'b0;
		load_word = '0;
		div_req   = '0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					if (q_job.is_auto) begin
						pop     = 1'b1;
						state_d = B_MUL;
					end else if (out_free) begin
						pop                  = 1'b1;
						load_out             = 1'b1;
						load_word.brightness = q_job.level;
						state_d              = B_IDLE;
					end
				end
			end
			B_MUL: begin
				state_d = (diff_s == '0) ? B_HOLD : B_SIGN;
			end
			B_SIGN: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_mag;
				div_req.divisor  = dvs_mag;
				state_d          = B_MAP;
			end
			B_MAP: begin
				if (div_rsp.done) begin
					state_d = B_HOLD;
				end
			end
			B_HOLD: begin
				if (out_free) begin
					load_out              = 1'b1;
					load_word.brightness  = res_q;
					load_word.from_sensor = 1'b1;
					state_d               = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath captures per step
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && pop && q_job.is_auto) begin
			avg_q <= SUM_W'(avg_prod[AVG_PROD_W-1:AVG_SHIFT]);
		end
		if (state_q == B_MUL) begin
			prod_q <= prod;
			neg_q  <= prod[DIV_W-1] ^ diff_s[DVS_W-1];
			res_q  <= cfg.level_min;
		end
		if (state_q == B_MAP && div_rsp.done) begin
			res_q <= t_clamp;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= load_word;
		end
	end

endmodule
